>>> hdl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and codes of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bmhq_pkg;

  localparam int KEY_W = 32;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_PLACE,
    S_LAST,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

>>> hdl/binary_max_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// Max-heap priority queue of signed 32-bit keys with push, pop and clear,
// separate signed compares stepping through the heap a level at a time.
// ----------------------------------------------------------------------------
`default_nettype none

// A word is taken when start_i is high and busy_o is low; the result comes
// back on the result ports for one cycle only, flagged by result_valid_o, and
// the receiver cannot hold it off. busy_o stays high from acceptance until the
// result cycle is over. A push steps up and a pop steps down the heap a level
// at a time; the pace is set by the key memory: each heap level needs one
// registered read and one write through its single write port, with signed
// compares in between. Pushes into an empty heap, clears and refused
// operations go straight to the result. No clearing pass is needed after
// reset.
module binary_max_heap_queue
  import bmhq_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic signed [31:0] key_in_i,
  output logic                   result_valid_o,
  output logic signed [31:0]     popped_key_o,
  output logic [1:0]             status_o,
  output logic [7:0]             entry_count_o,
  output logic signed [31:0]     top_key_o,
  output logic                   top_valid_o
);

  localparam int AW  = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int CHW = AW + 2;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    pos_q, pos_d;
  key_t             moving_q, moving_d;
  key_t             popped_q, popped_d;
  status_e          status_q, status_d;
  key_t             top_q;

  // key memory
  key_t             mem [CAPACITY];
  logic             we;
  logic [AW-1:0]    wa;
  key_t             wd;
  logic [AW-1:0]    ra_a, ra_b;
  key_t             rda_q, rdb_q;

  logic             accept;
  logic [AW-1:0]    parent;
  logic [CHW-1:0]   child, child_r, count_ext;
  logic             child_out, right_ok, take_right;
  key_t             sel_key;
  logic [AW-1:0]    sel_idx;
  logic             up_stop, dn_stop;

  function automatic logic [AW-1:0] parent_of(logic [AW-1:0] p);
    return (p - AW'(1)) >> 1;
  endfunction

  assign accept    = start_i && !busy_o;
  assign parent    = parent_of(pos_q);
  assign child     = CHW'({pos_q, 1'b1});
  assign child_r   = child + CHW'(1);
  assign count_ext = CHW'(count_q);
  assign child_out = (child >= count_ext);
  assign right_ok  = (child_r < count_ext);
  assign take_right = right_ok && (rda_q < rdb_q);
  assign sel_key   = take_right ? rdb_q : rda_q;
  assign sel_idx   = take_right ? child_r[AW-1:0] : child[AW-1:0];
  assign up_stop   = (rda_q >= moving_q);
  assign dn_stop   = (moving_q >= sel_key);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DONE;
          case (operation_i)
            OP_PUSH: begin
              if (count_q < CAP_CNT && count_q != '0) state_d = S_UP_CMP;
            end
            OP_POP: begin
              if (count_q > CW'(1)) state_d = S_LAST;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_UP_CMP: begin
        if (up_stop) state_d = S_DONE;
        else if (parent == '0) state_d = S_PLACE;
        else state_d = S_UP_CMP;
      end
      S_PLACE:  state_d = S_DONE;
      S_LAST:   state_d = S_DN_RD;
      S_DN_RD:  state_d = child_out ? S_DONE : S_DN_CMP;
      S_DN_CMP: state_d = dn_stop ? S_DONE : S_DN_RD;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d  = count_q;
    pos_d    = pos_q;
    moving_d = moving_q;
    popped_d = popped_q;
    status_d = status_q;
    we       = 1'b0;
    wa       = pos_q;
    wd       = moving_q;
    ra_a     = parent_of(parent);
    ra_b     = child_r[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        // speculative read: parent of the free slot, or the last key
        if (operation_i == OP_POP) ra_a = AW'(count_q - CW'(1));
        else ra_a = parent_of(count_q[AW-1:0]);
        if (accept) begin
          popped_d = '0;
          status_d = ST_OK;
          case (operation_i)
            OP_PUSH: begin
              if (count_q >= CAP_CNT) begin
                status_d = ST_FULL;
              end else begin
                count_d  = count_q + CW'(1);
                pos_d    = count_q[AW-1:0];
                moving_d = key_in_i;
                if (count_q == '0) begin
                  we = 1'b1;
                  wa = '0;
                  wd = key_in_i;
                end
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                popped_d = top_q;
                count_d  = count_q - CW'(1);
              end
            end
            OP_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (!up_stop) begin
          wd    = rda_q;
          pos_d = parent;
        end
      end
      S_PLACE: we = 1'b1;
      S_LAST: begin
        moving_d = rda_q;
        pos_d    = '0;
      end
      S_DN_RD: begin
        ra_a = child[AW-1:0];
        if (child_out) we = 1'b1;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (!dn_stop) begin
          wd    = sel_key;
          pos_d = sel_idx;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    moving_q <= moving_d;
    popped_q <= popped_d;
    if (we && wa == '0) top_q <= wd;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rda_q <= mem[ra_a];
    rdb_q <= mem[ra_b];
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);
  assign popped_key_o   = popped_q;
  assign status_o       = status_q;
  assign entry_count_o  = 8'(count_q);
  assign top_valid_o    = (count_q != '0);
  assign top_key_o      = top_valid_o ? top_q : '0;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("heap count beyond capacity");

  a_write_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && state_q != S_IDLE) |-> (CW'(wa) < count_q))
    else $error("key write outside held slots");

  a_result_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy_o)
    else $error("block still busy after result word");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted word did not make the block busy");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_q == ST_FULL) |-> (count_q == CAP_CNT))
    else $error("push refused while heap not full");
`endif

endmodule

`default_nettype wire

>>> verif/binary_max_heap_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue_tb
// Self-checking bench for the max-heap priority queue: a directed table of
// edge cases, then random grow, shrink and fill-to-capacity episodes. Each
// result word is checked against its fixed reply or a same-size bench heap.
// ----------------------------------------------------------------------------
module binary_max_heap_queue_tb;
  import bmhq_pkg::*;

  localparam int CAPACITY = 128;
  localparam int RANDOM_WORDS = 1950;
  localparam int QUIET_FROM = 1700;
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam key_t KEY_MAX = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN = 32'sh8000_0000;

  typedef struct packed {
    key_t       popped_key;
    status_e    status;
    logic [7:0] entry_count;
    key_t       top_key;
    logic       top_valid;
  } reply_t;

  typedef struct {
    logic [1:0] op;
    key_t       key;
    bit         fixed;
    reply_t     reply;
  } cmd_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [1:0]        operation_i;
  logic signed [31:0] key_in_i;
  logic              result_valid_o;
  logic signed [31:0] popped_key_o;
  logic [1:0]        status_o;
  logic [7:0]        entry_count_o;
  logic signed [31:0] top_key_o;
  logic              top_valid_o;

  // bench copy of the heap
  key_t        heap_keys [CAPACITY];
  int unsigned heap_size;
  reply_t      reply_q [$];
  cmd_row_t    directed [$];

  int mismatches;
  int n_push, n_pop, n_clear, n_nop, n_full, n_empty, peak_size;

  binary_max_heap_queue #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .key_in_i      (key_in_i),
    .result_valid_o(result_valid_o),
    .popped_key_o  (popped_key_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .top_key_o     (top_key_o),
    .top_valid_o   (top_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 400000);
    $display("Verification failed");
    $finish;
  end

  function automatic reply_t heap_step(logic [1:0] op, key_t key);
    reply_t      r;
    int unsigned pos;
    int unsigned parent;
    int unsigned child;
    key_t        moving;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_PUSH: begin
        if (heap_size >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          pos = heap_size;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (heap_keys[parent] >= key) break;
            heap_keys[pos] = heap_keys[parent];
            pos = parent;
          end
          heap_keys[pos] = key;
          heap_size++;
        end
      end
      OP_POP: begin
        if (heap_size == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped_key = heap_keys[0];
          heap_size--;
          moving = heap_keys[heap_size];
          pos = 0;
          // sift down, left child wins a tie
          while (2 * pos + 1 < heap_size) begin
            child = 2 * pos + 1;
            if (child + 1 < heap_size && heap_keys[child] < heap_keys[child + 1]) child++;
            if (moving >= heap_keys[child]) break;
            heap_keys[pos] = heap_keys[child];
            pos = child;
          end
          heap_keys[pos] = moving;
        end
      end
      OP_CLEAR: heap_size = 0;
      default: ;
    endcase
    r.entry_count = heap_size[7:0];
    r.top_valid = (heap_size != 0);
    r.top_key = (heap_size != 0) ? heap_keys[0] : '0;
    return r;
  endfunction

  function automatic cmd_row_t plain_row(logic [1:0] op, key_t key);
    cmd_row_t c;
    c.op = op;
    c.key = key;
    c.fixed = 1'b0;
    c.reply = '0;
    return c;
  endfunction

  function automatic cmd_row_t fixed_row(logic [1:0] op, key_t key, key_t popped,
                                         status_e st, logic [7:0] cnt, key_t top,
                                         logic vld);
    cmd_row_t c;
    c.op = op;
    c.key = key;
    c.fixed = 1'b1;
    c.reply.popped_key = popped;
    c.reply.status = st;
    c.reply.entry_count = cnt;
    c.reply.top_key = top;
    c.reply.top_valid = vld;
    return c;
  endfunction

  function automatic key_t pick_key();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      case ($urandom_range(0, 4))
        0: return KEY_MAX;
        1: return KEY_MIN;
        2: return 32'sd0;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    // narrow range so that equal keys meet in the heap
    if (sel < 40) return key_t'($signed($urandom_range(0, 16)) - 8);
    return key_t'($urandom);
  endfunction

  task automatic send_word(logic [1:0] op, key_t key, bit fixed, reply_t fixed_reply);
    reply_t predicted;
    @(negedge clk_i);
    start_i <= 1'b1;
    operation_i <= op;
    key_in_i <= key;
    do @(posedge clk_i); while (busy_o);
    predicted = heap_step(op, key);
    reply_q.push_back(fixed ? fixed_reply : predicted);
    case (op)
      OP_PUSH:  n_push++;
      OP_POP:   n_pop++;
      OP_CLEAR: n_clear++;
      default:  n_nop++;
    endcase
    if (predicted.status == ST_FULL) n_full++;
    if (predicted.status == ST_EMPTY) n_empty++;
    if (heap_size > peak_size) peak_size = heap_size;
  endtask

  task automatic idle_burst(int n);
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    // no new word may be taken while the queue runs dry
    @(negedge clk_i);
    start_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    reply_t want;
    if (rst_ni && result_valid_o) begin
      if (reply_q.size() == 0) begin
        $error("result word with nothing expected: popped_key %0d status %0d",
               popped_key_o, status_o);
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        if (popped_key_o !== want.popped_key) begin
          $error("popped_key: expected %0d, got %0d", want.popped_key, popped_key_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (entry_count_o !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count_o);
          mismatches++;
        end
        if (top_key_o !== want.top_key) begin
          $error("top_key: expected %0d, got %0d", want.top_key, top_key_o);
          mismatches++;
        end
        if (top_valid_o !== want.top_valid) begin
          $error("top_valid: expected %0d, got %0d", want.top_valid, top_valid_o);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int  sent;
    int  episode;
    int  len;
    int  push_pct;
    int  sel;
    bit  quiet;
    logic [1:0] op;
    reply_t none;

    none = '0;
    mismatches = 0;
    n_push = 0;
    n_pop = 0;
    n_clear = 0;
    n_nop = 0;
    n_full = 0;
    n_empty = 0;
    peak_size = 0;
    heap_size = 0;
    foreach (heap_keys[i]) heap_keys[i] = '0;

    rst_ni = 1'b0;
    start_i = 1'b0;
    operation_i = OP_PUSH;
    key_in_i = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // refused and no-op words on an empty heap, then the key extremes
    directed.push_back(fixed_row(OP_POP, 0, 0, ST_EMPTY, 0, 0, 1'b0));
    directed.push_back(fixed_row(OP_NOP, 123, 0, ST_OK, 0, 0, 1'b0));
    directed.push_back(fixed_row(OP_CLEAR, 0, 0, ST_OK, 0, 0, 1'b0));
    directed.push_back(fixed_row(OP_PUSH, KEY_MIN, 0, ST_OK, 1, KEY_MIN, 1'b1));
    directed.push_back(fixed_row(OP_PUSH, KEY_MAX, 0, ST_OK, 2, KEY_MAX, 1'b1));
    directed.push_back(fixed_row(OP_PUSH, 0, 0, ST_OK, 3, KEY_MAX, 1'b1));
    directed.push_back(fixed_row(OP_PUSH, -1, 0, ST_OK, 4, KEY_MAX, 1'b1));
    directed.push_back(fixed_row(OP_PUSH, KEY_MAX, 0, ST_OK, 5, KEY_MAX, 1'b1));
    directed.push_back(plain_row(OP_PUSH, 0));
    directed.push_back(plain_row(OP_NOP, -5));
    directed.push_back(fixed_row(OP_POP, 0, KEY_MAX, ST_OK, 5, KEY_MAX, 1'b1));
    directed.push_back(fixed_row(OP_POP, 0, KEY_MAX, ST_OK, 4, 0, 1'b1));
    directed.push_back(plain_row(OP_POP, 0));
    directed.push_back(plain_row(OP_POP, 0));
    directed.push_back(plain_row(OP_POP, 0));
    directed.push_back(fixed_row(OP_POP, 0, KEY_MIN, ST_OK, 0, 0, 1'b0));
    directed.push_back(fixed_row(OP_POP, 0, 0, ST_EMPTY, 0, 0, 1'b0));
    directed.push_back(plain_row(OP_PUSH, 7));
    directed.push_back(plain_row(OP_PUSH, 7));
    directed.push_back(plain_row(OP_PUSH, 3));
    directed.push_back(fixed_row(OP_CLEAR, 0, 0, ST_OK, 0, 0, 1'b0));
    directed.push_back(fixed_row(OP_PUSH, -42, 0, ST_OK, 1, -42, 1'b1));
    directed.push_back(plain_row(OP_CLEAR, 0));

    foreach (directed[i]) begin
      if ($urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 13));
      send_word(directed[i].op, directed[i].key, directed[i].fixed, directed[i].reply);
    end
    wait_drained();

    sent = 0;
    episode = 0;
    while (sent < RANDOM_WORDS) begin
      quiet = (sent >= QUIET_FROM);
      if (episode == 3) begin
        // fill to capacity, knock on the full heap, then empty it past zero
        while (heap_size < CAPACITY) begin
          if (!quiet && $urandom_range(0, 7) == 0) idle_burst($urandom_range(1, 13));
          send_word(OP_PUSH, pick_key(), 1'b0, none);
          sent++;
        end
        repeat (3) begin
          send_word(OP_PUSH, pick_key(), 1'b0, none);
          sent++;
        end
        while (heap_size > 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) idle_burst($urandom_range(1, 13));
          send_word(OP_POP, pick_key(), 1'b0, none);
          sent++;
        end
        send_word(OP_POP, pick_key(), 1'b0, none);
        sent++;
      end else begin
        case ($urandom_range(0, 2))
          0: push_pct = 75;
          1: push_pct = 25;
          default: push_pct = 50;
        endcase
        len = $urandom_range(20, 150);
        repeat (len) begin
          quiet = (sent >= QUIET_FROM);
          sel = $urandom_range(0, 99);
          if (sel < 2) op = OP_CLEAR;
          else if (sel < 4) op = OP_NOP;
          else if ($urandom_range(0, 99) < push_pct) op = OP_PUSH;
          else op = OP_POP;
          if (!quiet && $urandom_range(0, 5) == 0) idle_burst($urandom_range(1, 13));
          send_word(op, pick_key(), 1'b0, none);
          sent++;
        end
      end
      // let the queue run dry now and then before the next episode
      if (episode % 5 == 1) wait_drained();
      episode++;
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk_i);

    $display("covered %0d pushes, %0d pops, %0d clears, %0d unused-code words",
             n_push, n_pop, n_clear, n_nop);
    $display("full refusals %0d, empty refusals %0d, deepest heap %0d of %0d",
             n_full, n_empty, peak_size, CAPACITY);
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/bmhq_pkg.sv
hdl/binary_max_heap_queue.sv
verif/binary_max_heap_queue_tb.sv
